// ===== rtl/gltf_pkg.sv =====
package gltf_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR_MODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_ATTR    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOLD_ATTR      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_ATTR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNDERLINE_ATTR = 3'd5;

    localparam logic [7:0] RST_DISPLAY_WIDTH  = 8'd80;
    localparam logic       RST_COLOUR_MODE    = 1'b1;
    localparam logic [7:0] RST_NORMAL_ATTR    = 8'd7;
    localparam logic [7:0] RST_BOLD_ATTR      = 8'd15;
    localparam logic [7:0] RST_REVERSE_ATTR   = 8'd112;
    localparam logic [7:0] RST_UNDERLINE_ATTR = 8'd1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_RUN    = 8'hFF;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_B_UP   = 8'h42;
    localparam logic [7:0] CH_C_UP   = 8'h43;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_N_UP   = 8'h4E;
    localparam logic [7:0] CH_R_UP   = 8'h52;
    localparam logic [7:0] CH_U_UP   = 8'h55;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_C_LO   = 8'h63;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_N_LO   = 8'h6E;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CARET = 3'd1,
        PH_A_HI  = 3'd2,
        PH_A_LO  = 3'd3,
        PH_C_HI  = 3'd4,
        PH_C_LO  = 3'd5,
        PH_RUN   = 3'd6
    } phase_t;

    typedef struct packed {
        logic       func;
        logic [7:0] line_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [7:0] cell_count;
        logic       line_done;
    } out_item_t;

    typedef struct packed {
        logic [7:0] display_width;
        logic       colour_mode;
        logic [7:0] normal_attr;
        logic [7:0] bold_attr;
        logic [7:0] reverse_attr;
        logic [7:0] underline_attr;
    } cfg_t;

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                v = b - CH_ZERO;
            end else if (b >= CH_A_UP && b <= CH_F_UP) begin
                v = b - CH_SEVEN;
            end else if (b >= CH_A_LO && b <= CH_F_LO) begin
                v = b - CH_A_LO + HEX_TEN;
            end
            return v[3:0];
        end
    endfunction

endpackage

// ===== rtl/guide_line_token_formatter_core.sv =====
// path: input register, parse step, result register driving m_valid; waits under back-pressure
// throughput: one byte per cycle unless m_ready stalls a result; set by the input register
//   feeding the parse step and the single result register, refilled in the cycle it drains
// reset: aresetn synchronous, active low; clears both stages, parse state and
//   loads the register defaults (width 80, colour on, attributes 7/15/112/1)
module guide_line_token_formatter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gltf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gltf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  gltf_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output gltf_pkg::out_item_t               m_data
);

    gltf_pkg::cfg_t      cfg;
    logic                in_valid_reg;
    logic                in_valid_next;
    gltf_pkg::in_item_t  in_data_reg;
    logic                has_result;
    gltf_pkg::out_item_t result;
    logic                out_busy;
    logic                advance;

    gltf_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // a byte with no result never waits for the output register
    assign advance = in_valid_reg && (!has_result || !out_busy);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    gltf_token_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item       (in_data_reg),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    gltf_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && has_result),
        .load_data (result),
        .busy      (out_busy),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_line_end_is_space: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.line_done) |-> (m_data.cell_char == gltf_pkg::CH_SPACE))
        else $error("padding result is not a space");

    a_cells_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.line_done) |-> (m_data.cell_count != 8'd0))
        else $error("cell result with zero count");

    a_stall_keeps_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled byte lost from input register");

endmodule

// ===== rtl/gltf_cfg_regs.sv =====
module gltf_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gltf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gltf_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output gltf_pkg::cfg_t                    cfg
);

    gltf_pkg::cfg_t cfg_reg;
    gltf_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                gltf_pkg::CFG_DISPLAY_WIDTH:  cfg_next.display_width  = cfg_wr_data;
                gltf_pkg::CFG_COLOUR_MODE:    cfg_next.colour_mode    = cfg_wr_data[0];
                gltf_pkg::CFG_NORMAL_ATTR:    cfg_next.normal_attr    = cfg_wr_data;
                gltf_pkg::CFG_BOLD_ATTR:      cfg_next.bold_attr      = cfg_wr_data;
                gltf_pkg::CFG_REVERSE_ATTR:   cfg_next.reverse_attr   = cfg_wr_data;
                gltf_pkg::CFG_UNDERLINE_ATTR: cfg_next.underline_attr = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.display_width  <= gltf_pkg::RST_DISPLAY_WIDTH;
            cfg_reg.colour_mode    <= gltf_pkg::RST_COLOUR_MODE;
            cfg_reg.normal_attr    <= gltf_pkg::RST_NORMAL_ATTR;
            cfg_reg.bold_attr      <= gltf_pkg::RST_BOLD_ATTR;
            cfg_reg.reverse_attr   <= gltf_pkg::RST_REVERSE_ATTR;
            cfg_reg.underline_attr <= gltf_pkg::RST_UNDERLINE_ATTR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/gltf_token_step.sv =====
module gltf_token_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  gltf_pkg::cfg_t      cfg,
    input  gltf_pkg::in_item_t  item,
    input  logic                advance,
    output logic                has_result,
    output gltf_pkg::out_item_t result
);

    gltf_pkg::phase_t phase_reg;
    gltf_pkg::phase_t phase_next;
    logic [3:0]       nibble_reg;
    logic [3:0]       nibble_next;
    logic [7:0]       attr_reg;
    logic [7:0]       attr_next;
    logic [7:0]       cells_reg;
    logic [7:0]       cells_next;

    logic [7:0] b;
    logic       is_a;
    logic       is_b;
    logic       is_c;
    logic       is_n;
    logic       is_r;
    logic       is_u;
    logic [3:0] hex_b;
    logic [7:0] hex_char;
    logic [7:0] cell_attr;
    logic [8:0] cells_sum;
    logic [7:0] emit_count;

    assign b     = item.line_byte;
    assign is_a  = (b == gltf_pkg::CH_A_UP) || (b == gltf_pkg::CH_A_LO);
    assign is_b  = (b == gltf_pkg::CH_B_UP) || (b == gltf_pkg::CH_B_LO);
    assign is_c  = (b == gltf_pkg::CH_C_UP) || (b == gltf_pkg::CH_C_LO);
    assign is_n  = (b == gltf_pkg::CH_N_UP) || (b == gltf_pkg::CH_N_LO);
    assign is_r  = (b == gltf_pkg::CH_R_UP) || (b == gltf_pkg::CH_R_LO);
    assign is_u  = (b == gltf_pkg::CH_U_UP) || (b == gltf_pkg::CH_U_LO);
    assign hex_b = gltf_pkg::hex_value(b);
    assign hex_char  = {nibble_reg, hex_b};
    assign cell_attr = cfg.colour_mode ? attr_reg : 8'd0;
    assign cells_sum = {1'b0, cells_reg} + {1'b0, emit_count};

    // next parse phase
    always_comb begin
        phase_next = gltf_pkg::PH_IDLE;
        if (!item.func) begin
            unique case (phase_reg)
                gltf_pkg::PH_CARET: begin
                    if (is_a) begin
                        phase_next = gltf_pkg::PH_A_HI;
                    end else if (is_c) begin
                        phase_next = gltf_pkg::PH_C_HI;
                    end else if (is_b || is_r || is_u || is_n || b == gltf_pkg::CH_CARET) begin
                        phase_next = gltf_pkg::PH_IDLE;
                    end else if (b == gltf_pkg::CH_RUN) begin
                        phase_next = gltf_pkg::PH_RUN;
                    end
                end
                gltf_pkg::PH_A_HI: phase_next = gltf_pkg::PH_A_LO;
                gltf_pkg::PH_C_HI: phase_next = gltf_pkg::PH_C_LO;
                gltf_pkg::PH_A_LO,
                gltf_pkg::PH_C_LO,
                gltf_pkg::PH_RUN:  phase_next = gltf_pkg::PH_IDLE;
                default: begin
                    if (b == gltf_pkg::CH_CARET) begin
                        phase_next = gltf_pkg::PH_CARET;
                    end else if (b == gltf_pkg::CH_RUN) begin
                        phase_next = gltf_pkg::PH_RUN;
                    end
                end
            endcase
        end
    end

    // result and datapath state
    always_comb begin
        has_result         = 1'b0;
        result.cell_char   = (b == gltf_pkg::CH_NUL) ? gltf_pkg::CH_SPACE : b;
        result.cell_attr   = cell_attr;
        result.cell_count  = 8'd1;
        result.line_done   = 1'b0;
        emit_count         = 8'd1;
        nibble_next        = nibble_reg;
        attr_next          = attr_reg;
        cells_next         = cells_reg;
        if (item.func) begin
            has_result        = 1'b1;
            result.cell_char  = gltf_pkg::CH_SPACE;
            result.cell_attr  = cfg.colour_mode ? cfg.normal_attr : 8'd0;
            result.cell_count = (cells_reg < cfg.display_width)
                                ? (cfg.display_width - cells_reg) : 8'd0;
            result.line_done  = 1'b1;
            nibble_next       = 4'd0;
            attr_next         = cfg.normal_attr;
            cells_next        = 8'd0;
        end else begin
            unique case (phase_reg)
                gltf_pkg::PH_CARET: begin
                    if (is_b) begin
                        attr_next = (attr_reg == cfg.bold_attr) ? cfg.normal_attr
                                                                : cfg.bold_attr;
                    end else if (is_r) begin
                        attr_next = (attr_reg == cfg.reverse_attr) ? cfg.normal_attr
                                                                   : cfg.reverse_attr;
                    end else if (is_u) begin
                        attr_next = (attr_reg == cfg.underline_attr) ? cfg.normal_attr
                                                                     : cfg.underline_attr;
                    end else if (is_n) begin
                        attr_next = cfg.normal_attr;
                    end else if (b == gltf_pkg::CH_CARET) begin
                        has_result = 1'b1;
                    end else if (!is_a && !is_c && b != gltf_pkg::CH_RUN) begin
                        has_result = 1'b1;
                    end
                end
                gltf_pkg::PH_A_HI,
                gltf_pkg::PH_C_HI: nibble_next = hex_b;
                gltf_pkg::PH_A_LO: attr_next = hex_char;
                gltf_pkg::PH_C_LO: begin
                    has_result       = 1'b1;
                    result.cell_char = (hex_char == gltf_pkg::CH_NUL) ? gltf_pkg::CH_SPACE
                                                                      : hex_char;
                end
                gltf_pkg::PH_RUN: begin
                    has_result        = (b != gltf_pkg::CH_NUL);
                    result.cell_char  = gltf_pkg::CH_SPACE;
                    result.cell_count = b;
                    emit_count        = b;
                end
                default: begin
                    has_result = (b != gltf_pkg::CH_CARET) && (b != gltf_pkg::CH_RUN);
                end
            endcase
            if (has_result) begin
                cells_next = cells_sum[8] ? 8'hFF : cells_sum[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= gltf_pkg::PH_IDLE;
            nibble_reg <= 4'd0;
            attr_reg   <= gltf_pkg::RST_NORMAL_ATTR;
            cells_reg  <= 8'd0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            attr_reg   <= attr_next;
            cells_reg  <= cells_next;
        end
    end

endmodule

// ===== rtl/gltf_out_stage.sv =====
module gltf_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  gltf_pkg::out_item_t load_data,
    output logic                busy,
    input  logic                m_ready,
    output logic                m_valid,
    output gltf_pkg::out_item_t m_data
);

    logic                valid_reg;
    logic                valid_next;
    gltf_pkg::out_item_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign busy    = valid_reg && !m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
